FILE: design/additive_oscillator_bank_defines.svh
// Assertion macros for the additive oscillator bank.
// Used by the top level; no other dependencies.
`ifndef ADDITIVE_OSCILLATOR_BANK_DEFINES_SVH
`define ADDITIVE_OSCILLATOR_BANK_DEFINES_SVH

`ifndef SYNTHESIS
// Condition must hold in the same cycle as the trigger.
`define AOB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("aob assertion failed");
// Condition must hold in the cycle after the trigger.
`define AOB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("aob assertion failed");
`else
`define AOB_ASSERT_SAME(lbl, ante, cons)
`define AOB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: design/aob_pkg.sv
// Shared types and constants for the additive oscillator bank.
// No dependencies; used by additive_oscillator_bank.
package aob_pkg;

    // Bank geometry and field widths.
    localparam int PARTIAL_COUNT = 128;
    localparam int IDX_W         = $clog2(PARTIAL_COUNT);
    localparam int PHASE_BITS    = 24;
    localparam int GAIN_BITS     = 16;
    localparam int ENT_W         = 16;
    localparam int SEED_W        = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int SAMPLE_W      = 24;
    localparam int SG_W          = PHASE_BITS + GAIN_BITS;

    // Jitter arithmetic.
    localparam int AJ_W     = 17;
    localparam int RE_W     = ENT_W + 17;
    localparam int PM_W     = RE_W + 15;
    localparam int PJ_SHIFT = 47 - PHASE_BITS;
    localparam logic [ENT_W-1:0] ENTROPY_ON_ABOVE = ENT_W'(65);
    localparam logic signed [14:0] PJ_MUL = 15'sd13107;
    localparam logic [AJ_W:0] AJ_ONE = (AJ_W+1)'(65536);

    // Oscillator arithmetic.
    localparam int X_W     = PHASE_BITS + 1;
    localparam int PROD_W  = 2 * PHASE_BITS + 3;
    localparam int S_SHIFT = 2 * PHASE_BITS - 22;
    localparam int S_W     = 22;
    localparam int G_W     = GAIN_BITS + 1;
    localparam int TERM_W  = 23;
    localparam int ACC_W   = TERM_W + IDX_W + 1;
    localparam logic [GAIN_BITS-1:0] GAIN_TINY = GAIN_BITS'((1 << GAIN_BITS) / 10000);
    localparam logic [X_W-1:0] PHASE_ONE = X_W'(1) << PHASE_BITS;

    // Output saturation bounds in accumulator width.
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX - ACC_W'(1);

    // Request codes.
    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTROPY = 2'd0,
        CFG_SEED    = 2'd1
    } cfg_t;

    // Tick sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_JIT_DRAW,
        ST_JIT_MUL,
        ST_JIT_AJ,
        ST_JIT_PJ,
        ST_JIT_FIN,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // One xorshift32 step with shifts 13, 17 and 5.
    function automatic logic [SEED_W-1:0] xs32(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

FILE: design/additive_oscillator_bank.sv
// Additive oscillator bank: 128 parabolic-sine partials summed into one sample.
// Depends on aob_pkg and additive_oscillator_bank_defines.svh.
//
// A load word writes one partial's step and gain and a clear word zeroes all
// phases. A tick word walks the partials one per cycle through the single read
// port of the partial memories and one pipelined multiply-accumulate unit; with
// entropy on, two generator draws and the jitter multiplies come before the walk.
// The input is not ready while a tick is in flight; a finished sample waits in
// the output register while the next word is taken.
`include "additive_oscillator_bank_defines.svh"

module additive_oscillator_bank (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_req_type,
    input  logic [aob_pkg::IDX_W-1:0]             s_partial_index,
    input  logic [aob_pkg::PHASE_BITS-1:0]        s_phase_step,
    input  logic [aob_pkg::GAIN_BITS-1:0]         s_partial_gain,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [aob_pkg::SAMPLE_W-1:0]   m_sample_out,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [aob_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [aob_pkg::SEED_W-1:0]            cfg_data
);

    // Sequencer state.
    aob_pkg::state_t state_reg, state_next;

    // Configuration and generator.
    logic [aob_pkg::ENT_W-1:0]  entropy_reg;
    logic [aob_pkg::SEED_W-1:0] rng_reg;
    logic [aob_pkg::SEED_W-1:0] rng_draw;
    logic signed [15:0]         r_new;
    logic                       ent_on;

    // Jitter registers.
    logic signed [15:0]              r_reg;
    logic signed [aob_pkg::RE_W-1:0] re_reg;
    logic signed [aob_pkg::PM_W-1:0] pm_reg;
    logic [aob_pkg::AJ_W-1:0]        aj_reg;
    logic [aob_pkg::PHASE_BITS-1:0]  pj_reg;
    logic [aob_pkg::AJ_W:0]          aj_calc;

    // Partial memories and their valid bits.
    logic [aob_pkg::PHASE_BITS-1:0] phase_mem [aob_pkg::PARTIAL_COUNT];
    logic [aob_pkg::SG_W-1:0]       sg_mem    [aob_pkg::PARTIAL_COUNT];
    logic [aob_pkg::PARTIAL_COUNT-1:0] ph_vld_reg;
    logic [aob_pkg::PARTIAL_COUNT-1:0] sg_vld_reg;

    // Walk control and control decodes.
    logic [aob_pkg::IDX_W-1:0] idx_reg;
    logic accept, in_load, in_tick, in_clear;
    logic draw_en, issue_en, out_load, pipe_busy;

    // Stage 1: memory read data.
    logic                           p1_vld_reg;
    logic [aob_pkg::IDX_W-1:0]      idx1_reg;
    logic [aob_pkg::PHASE_BITS-1:0] phase_q_reg;
    logic [aob_pkg::SG_W-1:0]       sg_q_reg;
    logic                           phv1_reg, sgv1_reg;

    // Stage 1 combinational phase update.
    logic [aob_pkg::PHASE_BITS-1:0] phase_eff, step_eff, p_new;
    logic [aob_pkg::GAIN_BITS-1:0]  gain_eff;
    logic                           skip1;
    logic signed [aob_pkg::X_W-1:0] x1;
    logic [aob_pkg::X_W-1:0]        ax1, om1;

    // Stage 2: operands of the two multipliers.
    logic                           p2_vld_reg, skip2_reg;
    logic signed [aob_pkg::X_W-1:0] x2_reg;
    logic [aob_pkg::X_W-1:0]        om2_reg;
    logic [aob_pkg::GAIN_BITS-1:0]  gain2_reg;

    // Stage 3: shape product and jittered gain.
    logic                              p3_vld_reg, skip3_reg;
    logic signed [aob_pkg::PROD_W-1:0] prod_reg;
    logic [aob_pkg::G_W-1:0]           g3_reg;
    logic [aob_pkg::GAIN_BITS+aob_pkg::AJ_W-1:0] gprod;
    logic signed [aob_pkg::S_W-1:0]    s3;
    logic signed [aob_pkg::S_W+aob_pkg::G_W:0] tprod;

    // Stage 4: weighted term, then accumulator and output.
    logic                              p4_vld_reg, skip4_reg;
    logic signed [aob_pkg::TERM_W-1:0] term_reg;
    logic signed [aob_pkg::ACC_W-1:0]  acc_reg;
    logic signed [aob_pkg::SAMPLE_W-1:0] sat_val;
    logic                              m_valid_reg;
    logic signed [aob_pkg::SAMPLE_W-1:0] m_sample_reg;

    // Handshake decodes.
    assign s_ready   = (state_reg == aob_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign in_load   = accept && (s_req_type == aob_pkg::REQ_LOAD);
    assign in_tick   = accept && (s_req_type == aob_pkg::REQ_TICK);
    assign in_clear  = accept && (s_req_type == aob_pkg::REQ_CLEAR);
    assign ent_on    = (entropy_reg > aob_pkg::ENTROPY_ON_ABOVE);
    assign pipe_busy = p1_vld_reg || p2_vld_reg || p3_vld_reg || p4_vld_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            aob_pkg::ST_IDLE: begin
                if (in_tick) begin
                    state_next = ent_on ? aob_pkg::ST_JIT_DRAW : aob_pkg::ST_WALK;
                end
            end
            aob_pkg::ST_JIT_DRAW: state_next = aob_pkg::ST_JIT_MUL;
            aob_pkg::ST_JIT_MUL:  state_next = aob_pkg::ST_JIT_AJ;
            aob_pkg::ST_JIT_AJ:   state_next = aob_pkg::ST_JIT_PJ;
            aob_pkg::ST_JIT_PJ:   state_next = aob_pkg::ST_JIT_FIN;
            aob_pkg::ST_JIT_FIN:  state_next = aob_pkg::ST_WALK;
            aob_pkg::ST_WALK: begin
                if (idx_reg == aob_pkg::IDX_W'(aob_pkg::PARTIAL_COUNT - 1)) begin
                    state_next = aob_pkg::ST_DRAIN;
                end
            end
            aob_pkg::ST_DRAIN: begin
                if (!pipe_busy) begin
                    state_next = aob_pkg::ST_DONE;
                end
            end
            aob_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = aob_pkg::ST_IDLE;
                end
            end
            default: state_next = aob_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        draw_en  = (state_reg inside {aob_pkg::ST_JIT_DRAW, aob_pkg::ST_JIT_MUL});
        issue_en = (state_reg == aob_pkg::ST_WALK);
        out_load = (state_reg == aob_pkg::ST_DONE) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aob_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers and the random generator.
    assign rng_draw = aob_pkg::xs32(rng_reg);
    assign r_new    = {~rng_draw[15], rng_draw[14:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entropy_reg <= '0;
            rng_reg     <= aob_pkg::SEED_W'(1);
        end else begin
            if (cfg_valid && cfg_ready && (cfg_index == aob_pkg::CFG_ENTROPY)) begin
                entropy_reg <= cfg_data[aob_pkg::ENT_W-1:0];
            end
            if (cfg_valid && cfg_ready && (cfg_index == aob_pkg::CFG_SEED)) begin
                rng_reg <= (cfg_data == '0) ? aob_pkg::SEED_W'(1) : cfg_data;
            end else if (draw_en) begin
                rng_reg <= rng_draw;
            end
        end
    end

    // Per-tick gain and phase jitter.
    assign aj_calc = {re_reg[aob_pkg::RE_W-1], re_reg[aob_pkg::RE_W-1:16]} + aob_pkg::AJ_ONE;

    always_ff @(posedge aclk) begin
        if (draw_en) begin
            r_reg <= r_new;
        end
        case (state_reg)
            aob_pkg::ST_IDLE: begin
                if (in_tick && !ent_on) begin
                    aj_reg <= aob_pkg::AJ_ONE[aob_pkg::AJ_W-1:0];
                    pj_reg <= '0;
                end
            end
            aob_pkg::ST_JIT_MUL: re_reg <= r_reg * $signed({1'b0, entropy_reg});
            aob_pkg::ST_JIT_AJ: begin
                aj_reg <= aj_calc[aob_pkg::AJ_W-1:0];
                re_reg <= r_reg * $signed({1'b0, entropy_reg});
            end
            aob_pkg::ST_JIT_PJ:  pm_reg <= re_reg * aob_pkg::PJ_MUL;
            aob_pkg::ST_JIT_FIN: pj_reg <= pm_reg[aob_pkg::PJ_SHIFT +: aob_pkg::PHASE_BITS];
            default: ;
        endcase
    end

    // Walk counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (in_tick) begin
            idx_reg <= '0;
        end else if (issue_en) begin
            idx_reg <= idx_reg + aob_pkg::IDX_W'(1);
        end
    end

    // Step and gain memory: written by loads, read during the walk.
    always_ff @(posedge aclk) begin
        if (in_load) begin
            sg_mem[s_partial_index] <= {s_phase_step, s_partial_gain};
        end
        sg_q_reg <= sg_mem[idx_reg];
    end

    // Phase memory: read at the issue index, written back one stage later.
    always_ff @(posedge aclk) begin
        if (p1_vld_reg && !skip1) begin
            phase_mem[idx1_reg] <= p_new;
        end
        phase_q_reg <= phase_mem[idx_reg];
    end

    // Valid bits stand in for the zero reset of both memories.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_vld_reg <= '0;
            sg_vld_reg <= '0;
        end else begin
            if (in_load) begin
                sg_vld_reg[s_partial_index] <= 1'b1;
            end
            if (in_clear) begin
                ph_vld_reg <= '0;
            end else if (p1_vld_reg && !skip1) begin
                ph_vld_reg[idx1_reg] <= 1'b1;
            end
        end
    end

    // Stage 1: advance the phase and fold it into x and 1-|x|.
    always_comb begin
        phase_eff = phv1_reg ? phase_q_reg : '0;
        step_eff  = sgv1_reg ? sg_q_reg[aob_pkg::SG_W-1:aob_pkg::GAIN_BITS] : '0;
        gain_eff  = sgv1_reg ? sg_q_reg[aob_pkg::GAIN_BITS-1:0] : '0;
        skip1     = ent_on && (gain_eff <= aob_pkg::GAIN_TINY);
        p_new     = phase_eff + step_eff + pj_reg;
        x1        = $signed({~p_new[aob_pkg::PHASE_BITS-1],
                             p_new[aob_pkg::PHASE_BITS-2:0], 1'b0});
        ax1       = x1[aob_pkg::X_W-1] ? (~x1 + aob_pkg::X_W'(1)) : x1;
        om1       = aob_pkg::PHASE_ONE - ax1;
    end

    // Stage 3 combinational: jittered gain and shape value.
    assign gprod = gain2_reg * aj_reg;
    assign s3    = prod_reg[aob_pkg::S_SHIFT +: aob_pkg::S_W];
    assign tprod = s3 * $signed({1'b0, g3_reg});

    // Multiply-accumulate pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
        end else begin
            p1_vld_reg <= issue_en;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
        end
        idx1_reg  <= idx_reg;
        phv1_reg  <= ph_vld_reg[idx_reg];
        sgv1_reg  <= sg_vld_reg[idx_reg];
        x2_reg    <= x1;
        om2_reg   <= om1;
        gain2_reg <= gain_eff;
        skip2_reg <= skip1;
        prod_reg  <= x2_reg * $signed({1'b0, om2_reg});
        g3_reg    <= gprod[16 +: aob_pkg::G_W];
        skip3_reg <= skip2_reg;
        term_reg  <= tprod[aob_pkg::GAIN_BITS +: aob_pkg::TERM_W];
        skip4_reg <= skip3_reg;
    end

    // Accumulator over the walk.
    always_ff @(posedge aclk) begin
        if (in_tick) begin
            acc_reg <= '0;
        end else if (p4_vld_reg && !skip4_reg) begin
            acc_reg <= acc_reg + {{(aob_pkg::ACC_W - aob_pkg::TERM_W){term_reg[aob_pkg::TERM_W-1]}},
                                  term_reg};
        end
    end

    // Saturate the sum and hold it in the output register.
    always_comb begin
        if (acc_reg > aob_pkg::ACC_MAX) begin
            sat_val = aob_pkg::ACC_MAX[aob_pkg::SAMPLE_W-1:0];
        end else if (acc_reg < aob_pkg::ACC_MIN) begin
            sat_val = aob_pkg::ACC_MIN[aob_pkg::SAMPLE_W-1:0];
        end else begin
            sat_val = acc_reg[aob_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_sample_reg <= sat_val;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;

    // The input is taken only with the walk pipeline empty.
    `AOB_ASSERT_SAME(a_ready_idle, s_ready, !pipe_busy)
    // A new output word comes only from the final sequencer state.
    `AOB_ASSERT_NEXT(a_out_src, (state_reg == aob_pkg::ST_DONE) && (!m_valid_reg || m_ready), m_valid)
    // Partials are issued only while walking.
    `AOB_ASSERT_NEXT(a_issue, state_reg != aob_pkg::ST_WALK, !p1_vld_reg)
    // Gain jitter stays within half to one and a half of unity while walking.
    `AOB_ASSERT_SAME(a_aj_range, state_reg == aob_pkg::ST_WALK, aj_reg >= aob_pkg::AJ_W'(32768))

endmodule

FILE: test/tb.sv
// Self-checking testbench for additive_oscillator_bank.
// Depends on aob_pkg; predicts every tick sample and compares it with the
// m_ channel, with bursty input, receiver stalls and register changes.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aob_pkg::*;

    localparam logic [1:0]           REQ_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE2    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE3    = 2'd3;
    localparam int                   JITTER_ABOVE  = 65;
    localparam int                   TINY_GAIN     = (1 << GAIN_BITS) / 10000;
    localparam longint               PHASE_SPAN    = longint'(1) << PHASE_BITS;
    localparam longint               SAT_HI        = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint               SAT_LO        = -(longint'(1) << (SAMPLE_W - 1));
    localparam int                   WORDS_PER_SET = 147;
    localparam int                   HOLD_CYCLES   = 3000;
    localparam int                   RUN_LIMIT     = 1500000;
    localparam int                   DIRECTED_N    = 20;

    // One directed word; sample holds a hand-worked expectation when known is set.
    typedef struct packed {
        logic [1:0]                  req;
        logic [IDX_W-1:0]            idx;
        logic [PHASE_BITS-1:0]       step;
        logic [GAIN_BITS-1:0]        gain;
        logic                        known;
        logic signed [SAMPLE_W-1:0]  sample;
    } word_row_t;

    // Quarter-cycle steps give a sine of exactly -1, then 0, then +1 on later ticks.
    localparam word_row_t DIRECTED [DIRECTED_N] = '{
        '{REQ_TICK,   7'd0,   24'd0,       16'd0,      1'b1, 24'sd0},
        '{REQ_LOAD,   7'd0,   24'h400000,  16'hFFFF,   1'b0, 24'sd0},
        '{REQ_TICK,   7'd0,   24'd0,       16'd0,      1'b1, -24'sd1048560},
        '{REQ_CLEAR,  7'd0,   24'd0,       16'd0,      1'b0, 24'sd0},
        '{REQ_TICK,   7'd0,   24'd0,       16'd0,      1'b1, -24'sd1048560},
        '{REQ_LOAD,   7'd127, 24'hFFFFFF,  16'hFFFF,   1'b0, 24'sd0},
        '{REQ_TICK,   7'd0,   24'd0,       16'd0,      1'b0, 24'sd0},
        '{REQ_UNUSED, 7'd127, 24'hFFFFFF,  16'hFFFF,   1'b0, 24'sd0},
        '{REQ_CLEAR,  7'd0,   24'd0,       16'd0,      1'b0, 24'sd0},
        '{REQ_LOAD,   7'd1,   24'h400000,  16'hFFFF,   1'b0, 24'sd0},
        '{REQ_LOAD,   7'd2,   24'h400000,  16'hFFFF,   1'b0, 24'sd0},
        '{REQ_LOAD,   7'd3,   24'h400000,  16'hFFFF,   1'b0, 24'sd0},
        '{REQ_LOAD,   7'd4,   24'h400000,  16'hFFFF,   1'b0, 24'sd0},
        '{REQ_LOAD,   7'd5,   24'h400000,  16'hFFFF,   1'b0, 24'sd0},
        '{REQ_LOAD,   7'd6,   24'h400000,  16'hFFFF,   1'b0, 24'sd0},
        '{REQ_LOAD,   7'd7,   24'h400000,  16'hFFFF,   1'b0, 24'sd0},
        '{REQ_LOAD,   7'd8,   24'h400000,  16'hFFFF,   1'b0, 24'sd0},
        '{REQ_TICK,   7'd0,   24'd0,       16'd0,      1'b1, -24'sd8388608},
        '{REQ_TICK,   7'd0,   24'd0,       16'd0,      1'b1, 24'sd0},
        '{REQ_TICK,   7'd0,   24'd0,       16'd0,      1'b1, 24'sd8388607}
    };

    logic                          aclk            = 1'b0;
    logic                          aresetn         = 1'b0;
    logic                          s_valid         = 1'b0;
    logic                          s_ready;
    logic [1:0]                    s_req_type      = '0;
    logic [IDX_W-1:0]              s_partial_index = '0;
    logic [PHASE_BITS-1:0]         s_phase_step    = '0;
    logic [GAIN_BITS-1:0]          s_partial_gain  = '0;
    logic                          m_valid;
    logic                          m_ready         = 1'b0;
    logic signed [SAMPLE_W-1:0]    m_sample_out;
    logic                          cfg_valid       = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index       = '0;
    logic [SEED_W-1:0]             cfg_data        = '0;

    // Shadow copy of the bank and its registers.
    logic [PHASE_BITS-1:0]         phase_acc [PARTIAL_COUNT];
    logic [PHASE_BITS-1:0]         step_reg  [PARTIAL_COUNT];
    logic [GAIN_BITS-1:0]          gain_reg  [PARTIAL_COUNT];
    logic [SEED_W-1:0]             jitter_rng    = 32'd1;
    logic [ENT_W-1:0]              entropy_depth = '0;

    logic signed [SAMPLE_W-1:0]    expected_samples [$];
    logic signed [SAMPLE_W-1:0]    want;
    int                            fail_count  = 0;
    int                            cycle_count = 0;
    int                            burst_left  = 0;
    int                            hold_left   = 0;
    logic [15:0]                   ready_mask  = 16'hFFFF;

    additive_oscillator_bank i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_partial_index (s_partial_index),
        .s_phase_step    (s_phase_step),
        .s_partial_gain  (s_partial_gain),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_out    (m_sample_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // One xorshift32 step; returns the low half as a signed Q0.15 value.
    function automatic longint draw_jitter();
        logic [SEED_W-1:0] s;
        s = jitter_rng;
        s = s ^ (s << 13);
        s = s ^ (s >> 17);
        s = s ^ (s << 5);
        jitter_rng = s;
        return longint'(s[15:0]) - 32768;
    endfunction

    // Advances every live partial and sums the gain-weighted parabolic sines.
    function automatic logic signed [SAMPLE_W-1:0] tick_sample();
        bit     jitter_on;
        longint depth, amp_j, phase_j, acc, x, mag, sine, g;
        int     i;
        jitter_on = entropy_depth > JITTER_ABOVE;
        depth     = longint'(entropy_depth);
        amp_j     = 65536;
        phase_j   = 0;
        acc       = 0;
        if (jitter_on) begin
            amp_j   = 65536 + ((draw_jitter() * depth) >>> 16);
            phase_j = (draw_jitter() * depth * 13107) >>> (47 - PHASE_BITS);
        end
        for (i = 0; i < PARTIAL_COUNT; i++) begin
            // With jitter on, near-silent partials are frozen, phase included.
            if (jitter_on && gain_reg[i] <= TINY_GAIN) continue;
            phase_acc[i] = PHASE_BITS'(longint'(phase_acc[i]) + longint'(step_reg[i]) + phase_j);
            x    = 2 * longint'(phase_acc[i]) - PHASE_SPAN;
            mag  = (x < 0) ? -x : x;
            sine = (x * (PHASE_SPAN - mag)) >>> (2 * PHASE_BITS - 22);
            g    = (longint'(gain_reg[i]) * amp_j) >>> 16;
            acc += (sine * g) >>> GAIN_BITS;
        end
        if (acc > SAT_HI) acc = SAT_HI;
        if (acc < SAT_LO) acc = SAT_LO;
        return SAMPLE_W'(acc);
    endfunction

    // Offers one word in bursts with random gaps, then applies it to the shadow bank.
    task automatic send_word(input logic [1:0] req, input logic [IDX_W-1:0] idx,
                             input logic [PHASE_BITS-1:0] step,
                             input logic [GAIN_BITS-1:0] gain, input logic known,
                             input logic signed [SAMPLE_W-1:0] hand_sample);
        logic signed [SAMPLE_W-1:0] predicted;
        int                         gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 9) < 6) gap = 0;
            else if ($urandom_range(0, 9) == 0) gap = $urandom_range(20, 200);
            else gap = $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_valid         <= 1'b1;
        s_req_type      <= req;
        s_partial_index <= idx;
        s_phase_step    <= step;
        s_partial_gain  <= gain;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        case (req)
            REQ_LOAD: begin
                step_reg[idx] = step;
                gain_reg[idx] = gain;
            end
            REQ_TICK: begin
                predicted = tick_sample();
                expected_samples.push_back(known ? hand_sample : predicted);
            end
            REQ_CLEAR: begin
                foreach (phase_acc[j]) phase_acc[j] = '0;
            end
            default: ;
        endcase
    endtask

    // Register write; the caller lowers cfg_valid after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEED_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_ENTROPY) entropy_depth = data[ENT_W-1:0];
        else if (idx == CFG_SEED) jitter_rng = (data == '0) ? 32'd1 : data;
    endtask

    // Waits until every sample is back and trailing loads or clears are done.
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // Stimulus: reset, directed table, then randomized sets under several settings.
    initial begin
        int                    k, set_no, n, pick;
        logic [1:0]            req;
        logic [PHASE_BITS-1:0] step;
        logic [GAIN_BITS-1:0]  gain;
        foreach (phase_acc[j]) begin
            phase_acc[j] = '0;
            step_reg[j]  = '0;
            gain_reg[j]  = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < DIRECTED_N; k++) begin
            send_word(DIRECTED[k].req, DIRECTED[k].idx, DIRECTED[k].step,
                      DIRECTED[k].gain, DIRECTED[k].known, DIRECTED[k].sample);
        end
        settle();

        for (set_no = 1; set_no <= 6; set_no++) begin
            case (set_no)
                1: begin
                    // Jitter depth right at the threshold, still off.
                    write_reg(CFG_ENTROPY, 32'd65);
                    write_reg(CFG_SEED, 32'hFFFF_FFFF);
                    write_reg(CFG_SPARE2, $urandom);
                end
                2: begin
                    // First depth with jitter on; a zero seed must act as one.
                    write_reg(CFG_ENTROPY, 32'd66);
                    write_reg(CFG_SEED, 32'd0);
                end
                3: begin
                    write_reg(CFG_ENTROPY, 32'hFFFF);
                    write_reg(CFG_SEED, $urandom);
                end
                4: begin
                    write_reg(CFG_SPARE3, $urandom);
                    write_reg(CFG_ENTROPY, $urandom_range(0, 65535));
                    write_reg(CFG_SEED, 32'd1);
                end
                5: begin
                    write_reg(CFG_ENTROPY, $urandom_range(66, 65535));
                    write_reg(CFG_SEED, $urandom);
                end
                default: begin
                    write_reg(CFG_ENTROPY, 32'd0);
                end
            endcase
            cfg_valid <= 1'b0;

            n = 0;
            while (n < WORDS_PER_SET) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) req = REQ_LOAD;
                else if (pick < 88) req = REQ_TICK;
                else if (pick < 95) req = REQ_CLEAR;
                else req = REQ_UNUSED;
                case ($urandom_range(0, 5))
                    0: step = '0;
                    1: step = '1;
                    2: step = PHASE_BITS'($urandom_range(0, 4095));
                    default: step = PHASE_BITS'($urandom);
                endcase
                // Tiny gains matter once jitter is on; seven is the first live one.
                case ($urandom_range(0, 5))
                    0: gain = GAIN_BITS'($urandom_range(0, TINY_GAIN));
                    1: gain = GAIN_BITS'(TINY_GAIN + 1);
                    2: gain = '1;
                    default: gain = GAIN_BITS'($urandom);
                endcase
                send_word(req, IDX_W'($urandom_range(0, PARTIAL_COUNT - 1)), step, gain,
                          1'b0, '0);
                if (req != REQ_UNUSED) n++;
            end
            settle();
        end

        repeat (200) @(posedge aclk);
        if (fail_count == 0 && expected_samples.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Receiver: a periodically redrawn stall mask, and two long hold-offs
    // that let the output back up into the input.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (cycle_count == 4000 || cycle_count == 40000) begin
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            if (cycle_count % 256 == 0) begin
                case ($urandom_range(0, 2))
                    0: ready_mask <= 16'hFFFF;
                    1: ready_mask <= 16'($urandom) | 16'h0001;
                    default: ready_mask <= 16'h0101;
                endcase
            end
            m_ready <= ready_mask[cycle_count % 16];
        end
    end

    // Checks each accepted sample word against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t ns: unexpected sample, expected none, actual %0d",
                         $time, m_sample_out);
                fail_count++;
            end else begin
                want = expected_samples.pop_front();
                if (m_sample_out !== want) begin
                    $display("%0t ns: sample_out mismatch, expected %0d, actual %0d",
                             $time, want, m_sample_out);
                    fail_count++;
                end
            end
        end
    end

    // Cycle counter and run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end
endmodule
